@@ design/tcd_pkg.sv @@
// Shared types and constants of the track cache directory.
package tcd_pkg;

    localparam int SECTORS = 256;
    localparam logic [11:0] RAW_FRAME = 12'h930;
    localparam logic [4:0]  RAW_DATA  = 5'h10;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FAIL  = 2'd2,
        ACT_RUN   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_EVICT   = 3'd2,
        ST_RANGE   = 3'd3,
        ST_RAW     = 3'd4,
        ST_RUN     = 3'd5,
        ST_NO_RUN  = 3'd6,
        ST_DONE    = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        REG_SIZE   = 2'd0,
        REG_BLOCKS = 2'd1,
        REG_RAW    = 2'd2,
        REG_OFFSET = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] block;
        logic [3:0]  way;
        logic [7:0]  from_sector;
        logic        unchanged;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  way_used;
        logic [18:0] buffer_offset;
        logic [40:0] load_offset;
        logic [23:0] victim_track;
        logic        victim_dirty;
        logic [7:0]  run_start;
        logic [8:0]  run_count;
        logic [40:0] run_offset;
    } rsp_t;

endpackage

@@ design/tcd_ram.sv @@
// Generic single-port RAM with registered read.
module tcd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ design/track_cache_directory_lru.sv @@
// Top level of the track cache directory.
// Fully associative directory of WAYS track ways, one request at a time. A read
// or write walks the ways one per cycle through a shared match/age compare; a
// miss adds a sweep that clears the way's 256 dirty bits, one per cycle. A
// dirty-run query seeks the first dirty sector one per cycle, clears the run
// sector by sector with a read and then a clearing write, and then rereads all
// 256 bits to refresh the way's dirty flag. Load-failed clears the way's 256
// dirty bits. After reset the block clears the whole dirty-bit RAM before it
// takes the first request.
module track_cache_directory_lru #(
    parameter int WAYS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tcd_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tcd_pkg::rsp_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [39:0]   cfg_data
);
    import tcd_pkg::*;

    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AB = WB + 8;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_WIPE, S_OFS1, S_OFS2,
        S_RSEEK, S_RRUN, S_RANY, S_DONE, S_OUT
    } state_t;

    state_t state_reg;

    logic [3:0]  size_reg;
    logic [31:0] blocks_reg;
    logic        raw_reg;
    logic [39:0] img_reg;

    logic [WAYS-1:0] valid_reg, wdirty_reg;
    logic [23:0] track_reg [WAYS];
    logic [31:0] age_reg [WAYS];
    logic [31:0] agec_reg;

    req_t  req_reg;
    rsp_t  rsp_reg;
    logic [WB:0] idx_reg;
    logic [WB-1:0] way_reg;
    logic  hit_reg, empty_reg;
    logic [WB-1:0] hit_w_reg, empty_w_reg, lru_w_reg;
    logic [31:0] lru_age_reg;
    logic [8:0] sec_reg;
    logic [AB:0] clr_reg;
    logic  any_reg;
    logic [48:0] prod_reg;
    logic  rd_pend_reg;

    logic          ram_we, ram_q, ram_wd;
    logic [AB-1:0] ram_a;

    tcd_ram #(.WIDTH(1), .DEPTH(WAYS * SECTORS)) u_dirty (
        .clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wd), .rdata(ram_q)
    );

    logic [3:0]  size_u;
    logic [23:0] trk;
    logic [7:0]  sec;
    logic        way_ok;
    logic [WB-1:0] sel_w;
    logic [WB-1:0] in_w;
    rsp_t        rsp_init;

    assign size_u = (size_reg < 4'd8) ? 4'd8 : ((size_reg > 4'd11) ? 4'd11 : size_reg);
    assign trk    = req_reg.block[31:8];
    assign sec    = req_reg.block[7:0];
    assign in_w   = req_reg.way[WB-1:0];
    assign way_ok = ({28'd0, req_reg.way} < WAYS) && valid_reg[in_w];
    assign sel_w  = hit_reg ? hit_w_reg : (empty_reg ? empty_w_reg : lru_w_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = rsp_reg;

    // starting response of an accepted beat
    always_comb
    begin
        rsp_init = '0;
        rsp_init.way_used = in_data.way;
        if (in_data.action == ACT_FAIL) rsp_init.status = ST_DONE;
        else if (in_data.action == ACT_RUN) rsp_init.status = ST_NO_RUN;
    end

    // dirty RAM port: clear sweep, way wipe, run walk, or marking write
    always_comb
    begin
        ram_we = 1'b0;
        ram_wd = 1'b0;
        ram_a  = {way_reg, sec_reg[7:0]};
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                ram_a  = clr_reg[AB-1:0];
            end
            S_WIPE:  ram_we = 1'b1;
            S_RRUN:  ram_we = rd_pend_reg && ram_q;
            S_DONE:  ram_we = (req_reg.action == ACT_WRITE) && !req_reg.unchanged;
            default: ram_we = 1'b0;
        endcase
        if (state_reg == S_DONE)
        begin
            ram_wd = 1'b1;
            ram_a  = {way_reg, sec};
        end
        if (state_reg == S_RRUN)
        begin
            ram_a = {way_reg, sec_reg[7:0] - 8'd1};
            if (!(rd_pend_reg && ram_q))
            begin
                ram_a = {way_reg, sec_reg[7:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            size_reg    <= 4'd9;
            blocks_reg  <= 32'd1;
            raw_reg     <= 1'b0;
            img_reg     <= 40'd0;
            valid_reg   <= '0;
            wdirty_reg  <= '0;
            agec_reg    <= 32'd0;
            clr_reg     <= '0;
            rd_pend_reg <= 1'b0;
            for (int i = 0; i < WAYS; i++)
            begin
                age_reg[i] <= 32'd0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_SIZE:   size_reg   <= cfg_data[3:0];
                    REG_BLOCKS: blocks_reg <= cfg_data[31:0];
                    REG_RAW:    raw_reg    <= cfg_data[0];
                    REG_OFFSET: img_reg    <= cfg_data;
                    default:    raw_reg    <= raw_reg;
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AB+1)'(WAYS * SECTORS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg     <= in_data;
                        rsp_reg     <= rsp_init;
                        idx_reg     <= '0;
                        hit_reg     <= 1'b0;
                        empty_reg   <= 1'b0;
                        lru_w_reg   <= '0;
                        lru_age_reg <= 32'hffff_ffff;
                        sec_reg     <= (in_data.action == ACT_FAIL) ? 9'd0
                                                                    : {1'b0, in_data.from_sector};
                        way_reg     <= in_data.way[WB-1:0];
                        any_reg     <= 1'b0;
                        rd_pend_reg <= 1'b0;
                        unique case (action_t'(in_data.action)) inside
                            ACT_READ, ACT_WRITE:
                            begin
                                agec_reg <= agec_reg + 32'd1;
                                if (agec_reg == 32'hffff_ffff)
                                begin
                                    for (int i = 0; i < WAYS; i++) age_reg[i] <= 32'd0;
                                end
                                state_reg <= S_SCAN;
                            end
                            ACT_FAIL:
                            begin
                                if ({28'd0, in_data.way} < WAYS)
                                begin
                                    valid_reg[in_data.way[WB-1:0]]  <= 1'b0;
                                    wdirty_reg[in_data.way[WB-1:0]] <= 1'b0;
                                    state_reg <= S_WIPE;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_RSEEK;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // one way per cycle through the shared compare
                    if (req_reg.block >= blocks_reg)
                    begin
                        rsp_reg.status   <= ST_RANGE;
                        rsp_reg.way_used <= 4'd0;
                        state_reg <= S_OUT;
                    end
                    else if ((req_reg.action == ACT_WRITE) && raw_reg)
                    begin
                        rsp_reg.status   <= ST_RAW;
                        rsp_reg.way_used <= 4'd0;
                        state_reg <= S_OUT;
                    end
                    else if (idx_reg == (WB+1)'(WAYS))
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        if (valid_reg[idx_reg[WB-1:0]])
                        begin
                            if (!hit_reg && track_reg[idx_reg[WB-1:0]] == trk)
                            begin
                                hit_reg   <= 1'b1;
                                hit_w_reg <= idx_reg[WB-1:0];
                            end
                        end
                        else if (!empty_reg)
                        begin
                            empty_reg   <= 1'b1;
                            empty_w_reg <= idx_reg[WB-1:0];
                        end
                        if (idx_reg == '0 || age_reg[idx_reg[WB-1:0]] < lru_age_reg)
                        begin
                            lru_age_reg <= age_reg[idx_reg[WB-1:0]];
                            lru_w_reg   <= idx_reg[WB-1:0];
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    way_reg <= sel_w;
                    age_reg[sel_w] <= agec_reg;
                    rsp_reg.way_used      <= 4'(sel_w);
                    rsp_reg.buffer_offset <= 19'({11'd0, sec} << size_u);
                    if (hit_reg)
                    begin
                        rsp_reg.status <= ST_HIT;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rsp_reg.status <= empty_reg ? ST_EMPTY : ST_EVICT;
                        if (!empty_reg)
                        begin
                            rsp_reg.victim_track <= track_reg[sel_w];
                            rsp_reg.victim_dirty <= wdirty_reg[sel_w];
                        end
                        valid_reg[sel_w]  <= 1'b1;
                        wdirty_reg[sel_w] <= 1'b0;
                        track_reg[sel_w]  <= trk;
                        sec_reg   <= 9'd0;
                        state_reg <= S_WIPE;
                    end
                end
                S_WIPE:
                begin
                    sec_reg <= sec_reg + 9'd1;
                    if (sec_reg == 9'd255)
                    begin
                        state_reg <= (req_reg.action == ACT_FAIL) ? S_OUT : S_OFS1;
                    end
                end
                S_OFS1:
                begin
                    prod_reg <= {17'd0, trk, 8'd0} * 49'(RAW_FRAME);
                    state_reg <= S_OFS2;
                end
                S_OFS2:
                begin
                    if (raw_reg)
                    begin
                        rsp_reg.load_offset <= {1'b0, img_reg} + prod_reg[40:0]
                            + 41'(RAW_DATA);
                    end
                    else
                    begin
                        rsp_reg.load_offset <= {1'b0, img_reg}
                            + 41'({{17{1'b0}}, trk, 8'd0} << size_u);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if ((req_reg.action == ACT_WRITE) && !req_reg.unchanged)
                    begin
                        wdirty_reg[way_reg] <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_RSEEK:
                begin
                    // registered read: data for sec_reg arrives in the following cycle
                    if (!way_ok)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (rd_pend_reg && ram_q)
                    begin
                        rsp_reg.run_start <= sec_reg[7:0] - 8'd1;
                        rsp_reg.run_count <= 9'd0;
                        rd_pend_reg <= 1'b0;
                        sec_reg   <= sec_reg - 9'd1;
                        state_reg <= S_RRUN;
                    end
                    else if (sec_reg[8])
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        sec_reg <= sec_reg + 9'd1;
                    end
                end
                S_RRUN:
                begin
                    if (rd_pend_reg && ram_q)
                    begin
                        // clear this dirty bit, then read the next one
                        rsp_reg.run_count <= rsp_reg.run_count + 9'd1;
                        rd_pend_reg <= 1'b0;
                    end
                    else if (rd_pend_reg && !ram_q)
                    begin
                        sec_reg   <= 9'd0;
                        rd_pend_reg <= 1'b0;
                        state_reg <= S_RANY;
                    end
                    else if (sec_reg[8])
                    begin
                        sec_reg   <= 9'd0;
                        state_reg <= S_RANY;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        sec_reg <= sec_reg + 9'd1;
                    end
                end
                S_RANY:
                begin
                    if (rd_pend_reg && ram_q) any_reg <= 1'b1;
                    if (sec_reg[8] && rd_pend_reg)
                    begin
                        wdirty_reg[way_reg] <= any_reg || ram_q;
                        rsp_reg.status <= ST_RUN;
                        rsp_reg.run_offset <= {1'b0, img_reg} + 41'(
                            {9'd0, track_reg[way_reg], rsp_reg.run_start} << size_u);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        sec_reg <= sec_reg + 9'd1;
                    end
                end
                S_OUT:
                begin
                    if (out_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/tcd_checker.sv @@
// Port-level assertions for the track cache directory, bound to the top level.
module tcd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input tcd_pkg::rsp_t out_data
);
    import tcd_pkg::*;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid) else $error("result repeated");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("accepted twice");
    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_RANGE || out_data.status == ST_RAW))
        |-> (out_data.load_offset == 41'd0 && out_data.way_used == 4'd0))
        else $error("refused result carries data");
endmodule

bind track_cache_directory_lru tcd_checker u_tcd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ tb/tb_track_cache_directory_lru.sv @@
// Self-checking testbench of the track cache directory with an inline LRU predictor.
`timescale 1ns / 1ps

module tb_track_cache_directory_lru;
    import tcd_pkg::*;

    localparam int NWAYS = 16;
    localparam int DRAIN_CYCLES = 700;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [39:0] cfg_data = '0;

    track_cache_directory_lru #(.WAYS(NWAYS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // shadow configuration
    logic [3:0]  size_log2 = 4'd9;
    logic [31:0] block_count = 32'd1;
    logic        raw_layout = 1'b0;
    logic [39:0] base_offset = '0;

    // shadow directory
    logic        valid_q [NWAYS];
    logic [23:0] track_q [NWAYS];
    logic [31:0] age_q [NWAYS];
    logic [31:0] age_now;
    logic        sector_dirty [NWAYS][256];
    logic        way_dirt [NWAYS];

    req_t   pending_reqs [$];
    rsp_t   expected_rsps [$];
    logic   no_idle = 1'b0;
    int     errors = 0;
    int     accepted = 0;
    int     checked = 0;
    int     status_seen [8];
    longint cycles = 0;

    function automatic logic [3:0] clamped_size();
        if (size_log2 < 4'd8) return 4'd8;
        if (size_log2 > 4'd11) return 4'd11;
        return size_log2;
    endfunction

    function automatic void wipe_way(int w);
        for (int s = 0; s < 256; s++) sector_dirty[w][s] = 1'b0;
        way_dirt[w] = 1'b0;
    endfunction

    function automatic logic [40:0] track_image_offset(logic [23:0] trk);
        logic [63:0] base;
        base = {32'd0, trk, 8'd0};
        if (raw_layout) return 41'({24'd0, base_offset} + base * 64'h930 + 64'h10);
        return 41'({24'd0, base_offset} + (base << clamped_size()));
    endfunction

    // Compute the response of one request and advance the shadow directory.
    function automatic rsp_t lookup_directory(req_t r);
        rsp_t o;
        logic [23:0] trk;
        logic [7:0] sec;
        int w, s, start, cnt;
        bit found, any;
        logic [31:0] best;
        o = '0;
        trk = r.block[31:8];
        sec = r.block[7:0];
        w = 0;
        found = 0;
        o.way_used = r.way;
        if (r.action == ACT_READ || r.action == ACT_WRITE) begin
            o.way_used = '0;
            age_now = age_now + 1;
            if (age_now == 0) for (int i = 0; i < NWAYS; i++) age_q[i] = '0;
            if (r.block >= block_count) begin
                o.status = ST_RANGE;
                return o;
            end
            if (r.action == ACT_WRITE && raw_layout) begin
                o.status = ST_RAW;
                return o;
            end
            for (int i = 0; i < NWAYS && !found; i++)
                if (valid_q[i] && track_q[i] == trk) begin w = i; found = 1; end
            if (found) o.status = ST_HIT;
            else begin
                for (int i = 0; i < NWAYS && !found; i++)
                    if (!valid_q[i]) begin w = i; found = 1; end
                if (found) o.status = ST_EMPTY;
                else begin
                    best = age_q[0];
                    w = 0;
                    for (int i = 1; i < NWAYS; i++)
                        if (age_q[i] < best) begin best = age_q[i]; w = i; end
                    o.status = ST_EVICT;
                    o.victim_track = track_q[w];
                    o.victim_dirty = way_dirt[w];
                end
                o.load_offset = track_image_offset(trk);
                wipe_way(w);
                valid_q[w] = 1'b1;
                track_q[w] = trk;
            end
            age_q[w] = age_now;
            o.way_used = w[3:0];
            o.buffer_offset = 19'({56'd0, sec} << clamped_size());
            if (r.action == ACT_WRITE && !r.unchanged) begin
                sector_dirty[w][sec] = 1'b1;
                way_dirt[w] = 1'b1;
            end
        end else if (r.action == ACT_FAIL) begin
            valid_q[r.way] = 1'b0;
            wipe_way(r.way);
            o.status = ST_DONE;
        end else begin
            o.status = ST_NO_RUN;
            w = r.way;
            if (!valid_q[w]) return o;
            s = r.from_sector;
            while (s < 256 && !sector_dirty[w][s]) s++;
            if (s >= 256) return o;
            start = s;
            cnt = 0;
            while (s < 256 && sector_dirty[w][s]) begin
                sector_dirty[w][s] = 1'b0;
                cnt++;
                s++;
            end
            any = 0;
            for (int i = 0; i < 256; i++) if (sector_dirty[w][i]) any = 1;
            way_dirt[w] = any;
            o.status = ST_RUN;
            o.run_start = start[7:0];
            o.run_count = cnt[8:0];
            o.run_offset = 41'({24'd0, base_offset}
                + (({32'd0, track_q[w], 8'd0} + 64'(start)) << clamped_size()));
        end
        return o;
    endfunction

    task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: mismatch %s expected %0h actual %0h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // driver: feed pending requests, predict each accepted beat
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
        end else begin
            if (in_valid && in_ready) begin
                expected_rsps.push_back(lookup_directory(in_data));
                accepted++;
            end
            if (!in_valid || in_ready) begin
                if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 29)) begin
                    in_valid <= 1'b1;
                    in_data <= pending_reqs.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, compare each response beat
    always @(posedge clk or negedge rst_n) begin
        rsp_t e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response, expected none actual %0h",
                        $time, out_data);
                    errors++;
                end else begin
                    e = expected_rsps.pop_front();
                    checked++;
                    status_seen[e.status]++;
                    report_field("status", e.status, out_data.status);
                    report_field("way_used", e.way_used, out_data.way_used);
                    report_field("buffer_offset", e.buffer_offset, out_data.buffer_offset);
                    report_field("load_offset", e.load_offset, out_data.load_offset);
                    report_field("victim_track", e.victim_track, out_data.victim_track);
                    report_field("victim_dirty", e.victim_dirty, out_data.victim_dirty);
                    report_field("run_start", e.run_start, out_data.run_start);
                    report_field("run_count", e.run_count, out_data.run_count);
                    report_field("run_offset", e.run_offset, out_data.run_offset);
                end
            end
            out_ready <= no_idle || ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(reg_index_t idx, logic [39:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready)) @(posedge clk);
        case (idx)
            REG_SIZE:   size_log2 = value[3:0];
            REG_BLOCKS: block_count = value[31:0];
            REG_RAW:    raw_layout = value[0];
            default:    base_offset = value;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_layout(logic [3:0] sz, logic [31:0] blocks, logic raw, logic [39:0] ofs);
        write_reg(REG_SIZE, {36'd0, sz});
        write_reg(REG_BLOCKS, {8'd0, blocks});
        write_reg(REG_RAW, {39'd0, raw});
        write_reg(REG_OFFSET, ofs);
    endtask

    task automatic push_req(action_t a, logic [31:0] blk, logic [3:0] w, logic [7:0] from,
                            logic unch);
        req_t r;
        r.action = a;
        r.block = blk;
        r.way = w;
        r.from_sector = from;
        r.unchanged = unch;
        pending_reqs.push_back(r);
    endtask

    // Mostly accesses within a small pool of tracks so hits, evictions and runs occur.
    task automatic push_random(int n, int pool);
        req_t r;
        int pick;
        repeat (n) begin
            r.block = $urandom();
            r.way = $urandom_range(0, 15);
            r.from_sector = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
            r.unchanged = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 38) r.action = ACT_READ;
            else if (pick < 75) r.action = ACT_WRITE;
            else if (pick < 80) r.action = ACT_FAIL;
            else r.action = ACT_RUN;
            if ($urandom_range(0, 9) != 0)
                r.block = {24'($urandom_range(0, pool - 1)),
                           ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                       : 8'($urandom_range(0, 255))};
            pending_reqs.push_back(r);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        age_now = '0;
        for (int i = 0; i < NWAYS; i++) begin
            valid_q[i] = 1'b0;
            track_q[i] = '0;
            age_q[i] = '0;
            wipe_way(i);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset layout: one-sector image
        push_req(ACT_READ, 32'd0, 4'd0, 8'd0, 1'b0);
        push_req(ACT_READ, 32'd0, 4'd0, 8'd0, 1'b0);
        push_req(ACT_READ, 32'd1, 4'd0, 8'd0, 1'b0);
        push_req(ACT_WRITE, 32'hffff_ffff, 4'd0, 8'd0, 1'b0);
        push_req(ACT_WRITE, 32'd0, 4'd0, 8'd0, 1'b0);
        push_req(ACT_RUN, 32'd0, 4'd0, 8'd0, 1'b0);
        push_req(ACT_RUN, 32'd0, 4'd0, 8'd0, 1'b0);
        push_req(ACT_RUN, 32'd0, 4'd15, 8'd255, 1'b1);
        push_req(ACT_FAIL, 32'd0, 4'd0, 8'd0, 1'b0);
        drain();

        // smallest sectors, partial last track, offset at its top
        set_layout(4'd8, 32'd20 * 256 - 7, 1'b0, 40'hff_ffff_ffff);
        for (int t = 0; t < 17; t++)
            push_req((t % 2) ? ACT_WRITE : ACT_READ, 32'(t * 256 + t), 4'd0, 8'd0, 1'b0);
        push_req(ACT_READ, 32'd20 * 256 - 8, 4'd0, 8'd0, 1'b0);
        push_req(ACT_READ, 32'd20 * 256 - 7, 4'd0, 8'd0, 1'b0);
        push_req(ACT_WRITE, 32'd3 * 256 + 255, 4'd0, 8'd0, 1'b1);
        push_req(ACT_RUN, 32'd0, 4'd3, 8'd0, 1'b0);
        push_req(ACT_FAIL, 32'd0, 4'd7, 8'd0, 1'b0);
        drain();
        push_random(360, 22);
        drain();

        // largest sectors, full address space, no idling for a stretch
        set_layout(4'd11, 32'hffff_ffff, 1'b0, {8'($urandom()), 32'($urandom())});
        no_idle = 1'b1;
        push_random(180, 40);
        drain();
        no_idle = 1'b0;
        push_random(180, 18);
        drain();

        // raw layout, read only
        set_layout(4'd11, 32'd30 * 256, 1'b1, {8'($urandom()), 32'($urandom())});
        push_random(360, 30);
        drain();

        // out-of-range size codes clamp at both ends
        set_layout(4'd15, 32'd24 * 256, 1'b0, 40'd0);
        push_random(180, 24);
        drain();
        write_reg(REG_SIZE, 40'd0);
        push_random(190, 24);
        drain();

        $display("%0d requests accepted, %0d responses checked", accepted, checked);
        $display("status mix hit/empty/evict/range/raw/run/norun/done: %0d %0d %0d %0d %0d %0d %0d %0d",
            status_seen[0], status_seen[1], status_seen[2], status_seen[3],
            status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
